FILE: hw/rtl/envc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor compensation package
// Shared types, register indexes and helper functions.
// ----------------------------------------------------------------------------
package envc_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int QueueDepthDefault = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP  = 3'd0,
    REG_PLOW  = 3'd1,
    REG_PHIGH = 3'd2,
    REG_P9    = 3'd3,
    REG_HUM   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] temperature_centideg;
    logic [31:0]        pressure_pascal;
    logic [16:0]        humidity_q22_10;
  } out_item_t;

  // Item passed from the temperature front to the back end.
  typedef struct packed {
    logic [31:0] fine;
    logic [23:0] temp;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
  } mid_item_t;

  typedef struct packed {
    logic [47:0] temp_c;
    logic [63:0] plow;
    logic [63:0] phigh;
    logic [15:0] p9;
    logic [63:0] hum_c;
  } coeffs_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

FILE: hw/rtl/env_sensor_int32_compensation.sv
// Path: front pipeline, queue, back pipeline, result register. The 32-stage restoring
// divider is fully pipelined: one transaction per cycle while out_stall is low.
// Reset: synchronous rst clears all valid flags and the coefficient registers to zero.
// A stalled output holds the whole back pipeline; the queue absorbs front results.
// ----------------------------------------------------------------------------
// Sensor compensation top level
// Register file, front end, queue and back end of the integer compensation.
// ----------------------------------------------------------------------------
module env_sensor_int32_compensation import envc_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  coeffs_t coeffs;

  // Hold coefficients; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEMP:  coeffs.temp_c <= cfg_data[47:0];
        REG_PLOW:  coeffs.plow   <= cfg_data;
        REG_PHIGH: coeffs.phigh  <= cfg_data;
        REG_P9:    coeffs.p9     <= cfg_data[15:0];
        REG_HUM:   coeffs.hum_c  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic      f_valid, f_stall, q_valid, q_stall;
  mid_item_t f_data, q_data;

  envc_front u_front (
    .clk(clk), .rst(rst), .coeffs(coeffs),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .mid_valid(f_valid), .mid_stall(f_stall), .mid_data(f_data)
  );

  envc_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
  );

  envc_back u_back (
    .clk(clk), .rst(rst), .coeffs(coeffs),
    .mid_valid(q_valid), .mid_stall(q_stall), .mid_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

FILE: hw/rtl/envc_front.sv
// ----------------------------------------------------------------------------
// Sensor compensation front end
// Accept readings and work out fine temperature in a short pipeline.
// ----------------------------------------------------------------------------
module envc_front import envc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  coeffs_t   coeffs,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      mid_valid,
  input  logic      mid_stall,
  output mid_item_t mid_data
);

  logic        s1_valid, s2_valid, s3_valid;
  in_item_t    s1_in;
  logic [31:0] s1_pa;
  logic [31:0] s2_a, s2_dd;
  logic [19:0] s2_p, s3_p;
  logic [15:0] s2_h, s3_h;
  logic [31:0] s3_fine;
  logic        adv;
  logic [31:0] t1, t2, t3, d, fa, fb, f5;

  assign adv       = !(mid_valid && mid_stall);
  assign in_stall  = !adv;
  assign mid_valid = s3_valid;

  assign t1 = {16'd0, coeffs.temp_c[15:0]};
  assign t2 = sx16(coeffs.temp_c[31:16]);
  assign t3 = sx16(coeffs.temp_c[47:32]);
  assign d  = {16'd0, s1_in.raw_temperature[19:4]} - t1;
  assign fa = asr(mul32(s1_pa, t2), 11);
  assign fb = asr(mul32(s2_dd, t3), 14);
  assign f5 = asr(mul32(s3_fine, 32'd5) + 32'd128, 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    if (adv) begin
      s1_in   <= in_data;
      s1_pa   <= {15'd0, in_data.raw_temperature[19:3]} - {15'd0, coeffs.temp_c[15:0], 1'b0};
      s2_a    <= fa;
      s2_dd   <= asr(mul32(d, d), 12);
      s2_p    <= s1_in.raw_pressure;
      s2_h    <= s1_in.raw_humidity;
      s3_fine <= s2_a + fb;
      s3_p    <= s2_p;
      s3_h    <= s2_h;
    end
  end

  assign mid_data = '{fine: s3_fine, temp: f5[23:0], adc_p: s3_p, adc_h: s3_h};

endmodule

FILE: hw/rtl/envc_queue.sv
// ----------------------------------------------------------------------------
// Sensor compensation queue
// Small FIFO between front and back ends.
// ----------------------------------------------------------------------------
module envc_queue import envc_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_stall,
  input  mid_item_t wr_data,
  output logic      rd_valid,
  input  logic      rd_stall,
  output mid_item_t rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  mid_item_t        mem [Depth];
  logic [AW-1:0]    wp, rp;
  logic [AW:0]      cnt;
  logic             wr, rd;

  assign wr_stall = (cnt == (AW+1)'(Depth));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem[wp] <= wr_data;
  end

endmodule

FILE: hw/rtl/envc_div.sv
// ----------------------------------------------------------------------------
// Sensor compensation divider
// Pipelined unsigned 32 by 32 divider, one quotient bit a stage.
// ----------------------------------------------------------------------------
module envc_div import envc_pkg::*; #(
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [31:0]     num,
  input  logic [31:0]     den,
  input  logic [TagW-1:0] tag_in,
  output logic [31:0]     quo,
  output logic [TagW-1:0] tag_out
);

  logic [31:0]     q  [33];
  logic [31:0]     r  [33];
  logic [31:0]     dv [33];
  logic [TagW-1:0] tg [33];

  assign q[0]  = num;
  assign r[0]  = '0;
  assign dv[0] = den;
  assign tg[0] = tag_in;

  for (genvar i = 0; i < 32; i++) begin : g_st
    logic [32:0] rs, df;
    assign rs = {r[i], q[i][31]};
    assign df = rs - {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        q[i+1]  <= {q[i][30:0], !df[32]};
        r[i+1]  <= df[32] ? rs[31:0] : df[31:0];
        dv[i+1] <= dv[i];
        tg[i+1] <= tg[i];
      end
    end
  end

  assign quo     = q[32];
  assign tag_out = tg[32];

endmodule

FILE: hw/rtl/envc_back.sv
// ----------------------------------------------------------------------------
// Sensor compensation back end
// Pressure and humidity pipelines, divider, output register.
// ----------------------------------------------------------------------------
module envc_back import envc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  coeffs_t   coeffs,
  input  logic      mid_valid,
  output logic      mid_stall,
  input  mid_item_t mid_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int NPre  = 6;
  localparam int NDiv  = 32;
  localparam int NPost = 3;
  localparam int NTot  = NPre + NDiv + NPost;
  // tag: temperature, humidity product, large dividend, zero divisor
  localparam int TagW  = 24 + 32 + 1 + 1;

  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign p1 = {16'd0, coeffs.plow[15:0]};
  assign p2 = sx16(coeffs.plow[31:16]);
  assign p3 = sx16(coeffs.plow[47:32]);
  assign p4 = sx16(coeffs.plow[63:48]);
  assign p5 = sx16(coeffs.phigh[15:0]);
  assign p6 = sx16(coeffs.phigh[31:16]);
  assign p7 = sx16(coeffs.phigh[47:32]);
  assign p8 = sx16(coeffs.phigh[63:48]);
  assign p9 = sx16(coeffs.p9);
  assign h1 = {24'd0, coeffs.hum_c[7:0]};
  assign h2 = sx16(coeffs.hum_c[23:8]);
  assign h3 = {24'd0, coeffs.hum_c[31:24]};
  assign h4 = {{20{coeffs.hum_c[43]}}, coeffs.hum_c[43:32]};
  assign h5 = {{20{coeffs.hum_c[55]}}, coeffs.hum_c[55:44]};
  assign h6 = {{24{coeffs.hum_c[63]}}, coeffs.hum_c[63:56]};

  // Pipeline advances whenever the output register can take a result.
  logic adv;
  logic [NTot-1:0] vld;
  assign adv       = !(out_valid && out_stall);
  assign mid_stall = !adv;
  assign out_valid = vld[NTot-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NTot-2:0], mid_valid};
  end

  // ---- pre-divide stages ----
  logic [31:0] a1, d1, ha1;
  logic [31:0] s1_a, s1_d;
  logic [19:0] s1_p, s2_p, s3_p, s4_p;
  logic [23:0] tq [NPre];
  logic [31:0] s2_sq, s2_pa5, s2_p2a;
  logic [31:0] s3_b, s3_at;
  logic [31:0] s4_b, s4_a;
  logic [31:0] s5_b, s5_den;
  logic [31:0] s6_num, s6_den;
  logic        s6_big, s6_zero;
  // humidity
  logic [31:0] hs1_a;
  logic [15:0] hs1_h;
  logic [31:0] hs2_x, hs2_ah6, hs2_ah3;
  logic [31:0] hs3_x, hs3_b, hs3_c;
  logic [31:0] hs4_x, hs4_b;
  logic [31:0] hs5_x, hs5_b;
  logic [31:0] hs6_m;

  assign a1 = asr(mid_data.fine, 1) - 32'd64000;
  assign d1 = asr(a1, 2);
  assign ha1 = mid_data.fine - 32'd76800;

  logic [31:0] hterm;
  assign hterm = asr(((( {16'd0, hs1_h} << 14) - (h4 << 20)) - mul32(h5, hs1_a))
                     + 32'd16384, 15);

  logic [31:0] s3_sum, hb3, hb4, hd_a;
  assign s3_sum = asr(asr(mul32(p3, asr(s2_sq, 13)), 3) + asr(s2_p2a, 1), 18);
  assign hb3 = asr(hs2_ah6, 10);
  assign hb4 = asr(mul32(hs3_b, hs3_c), 10) + 32'd2097152;
  assign hd_a = mul32(hs5_x, hs5_b);

  always_ff @(posedge clk) begin
    if (adv) begin
      tq[0] <= mid_data.temp;
      for (int i = 1; i < NPre; i++) tq[i] <= tq[i-1];
      // stage 1
      s1_a  <= a1;
      s1_d  <= d1;
      s1_p  <= mid_data.adc_p;
      hs1_a <= ha1;
      hs1_h <= mid_data.adc_h;
      // stage 2
      s2_sq  <= mul32(s1_d, s1_d);
      s2_pa5 <= mul32(s1_a, p5) << 1;
      s2_p2a <= mul32(p2, s1_a);
      s2_p   <= s1_p;
      hs2_x   <= hterm;
      hs2_ah6 <= mul32(hs1_a, h6);
      hs2_ah3 <= asr(mul32(hs1_a, h3), 11) + 32'd32768;
      // stage 3
      s3_b  <= mul32(asr(s2_sq, 11), p6) + s2_pa5;
      s3_at <= s3_sum;
      s3_p  <= s2_p;
      hs3_x <= hs2_x;
      hs3_b <= hb3;
      hs3_c <= hs2_ah3;
      // stage 4
      s4_b  <= asr(s3_b, 2) + (p4 << 16);
      s4_a  <= mul32(32'd32768 + s3_at, p1);
      s4_p  <= s3_p;
      hs4_x <= hs3_x;
      hs4_b <= hb4;
      // stage 5
      s5_b   <= mul32((32'd1048576 - {12'd0, s4_p}) - asr(s4_b, 12), 32'd3125);
      s5_den <= asr(s4_a, 15);
      hs5_x  <= hs4_x;
      hs5_b  <= asr(mul32(hs4_b, h2) + 32'd8192, 14);
      // stage 6
      s6_big  <= s5_b[31];
      s6_num  <= s5_b[31] ? s5_b : (s5_b << 1);
      s6_den  <= s5_den;
      s6_zero <= (s5_den == '0);
      hs6_m   <= hd_a;
    end
  end

  // ---- divider; zero divisor gives an all-ones quotient, masked later ----
  logic [31:0]     quo;
  logic [TagW-1:0] tag_o;
  envc_div #(.TagW(TagW)) u_div (
    .clk(clk), .adv(adv), .num(s6_num), .den(s6_den),
    .tag_in({tq[NPre-1], hs6_m, s6_big, s6_zero}),
    .quo(quo), .tag_out(tag_o)
  );

  // ---- post-divide stages ----
  logic [31:0] pq1, pq2, y1a, y2a, pq3;
  logic [TagW-1:0] pt1, pt2, pt3;
  logic [31:0] pd, sq3;
  logic [31:0] hd_d, hd_sq, hd_fin;
  logic [16:0] hum_out, hum2, hum3;
  assign pd = tag_o[1] ? (quo << 1) : quo;
  assign sq3 = mul32({3'd0, pq1[31:3]}, {3'd0, pq1[31:3]});

  // Finish humidity over two stages: square term first, then correct and clamp.
  assign hd_d   = asr(tag_o[33:2], 15);
  assign hd_fin = pt1[33:2] - asr(mul32(hd_sq, h1), 4);
  always_comb begin
    if (hd_fin[31])                hum_out = '0;
    else if (hd_fin > 32'd419430400) hum_out = 17'd102400;
    else                           hum_out = hd_fin[28:12];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pq1 <= pd;
      pt1 <= tag_o;
      hd_sq <= asr(mul32(hd_d, hd_d), 7);
      pq2 <= pq1;
      pt2 <= pt1;
      hum2 <= hum_out;
      y1a <= sq3 >> 13;
      y2a <= asr(mul32({2'd0, pq1[31:2]}, p8), 13);
      pq3 <= pt2[0] ? 32'd0 : pq2 + asr(asr(mul32(p9, y1a), 12) + y2a + p7, 4);
      pt3 <= pt2;
      hum3 <= hum2;
    end
  end

  assign out_data = '{temperature_centideg: pt3[TagW-1 -: 24],
                      pressure_pascal: pq3,
                      humidity_q22_10: hum3};

endmodule

FILE: tb/env_sensor_int32_compensation_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor compensation checker
// Watches both channels and the register port, works out the compensated
// reading for every accepted input transaction and compares it with the
// oldest outstanding one when a result transaction is accepted.
// ----------------------------------------------------------------------------
module env_sensor_int32_compensation_chk import envc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  output int                  errors,
  output int                  pending,
  output int                  seen
);

  logic [47:0] k_temp;
  logic [63:0] k_plow, k_phigh, k_hum;
  logic [15:0] k_p9;
  out_item_t   readings_due[$];

  function automatic logic [31:0] wmul(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext(logic [63:0] v, int pos, int w);
    logic [31:0] x, m;
    x = 32'((v >> pos) & ((64'd1 << w) - 64'd1));
    m = 32'd1 << (w - 1);
    return (x ^ m) - m;
  endfunction

  function automatic out_item_t compensate(in_item_t it);
    logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, a, b, d, sq, fine, tmp, pr, y1, y2;
    out_item_t r;
    at = {12'd0, it.raw_temperature};
    ap = {12'd0, it.raw_pressure};
    ah = {16'd0, it.raw_humidity};
    t1 = {16'd0, k_temp[15:0]};
    t2 = sext(k_temp, 16, 16);  t3 = sext(k_temp, 32, 16);
    p1 = {16'd0, k_plow[15:0]};
    p2 = sext(k_plow, 16, 16);  p3 = sext(k_plow, 32, 16);
    p4 = sext(k_plow, 48, 16);  p5 = sext(k_phigh, 0, 16);
    p6 = sext(k_phigh, 16, 16); p7 = sext(k_phigh, 32, 16);
    p8 = sext(k_phigh, 48, 16); p9 = sext({48'd0, k_p9}, 0, 16);
    h1 = {24'd0, k_hum[7:0]};   h2 = sext(k_hum, 8, 16);
    h3 = {24'd0, k_hum[31:24]}; h4 = sext(k_hum, 32, 12);
    h5 = sext(k_hum, 44, 12);   h6 = sext(k_hum, 56, 8);
    // fine temperature first; it feeds both other paths
    a = sra(wmul((at >> 3) - (t1 << 1), t2), 11);
    d = (at >> 4) - t1;
    b = sra(wmul(sra(wmul(d, d), 12), t3), 14);
    fine = a + b;
    tmp = sra(wmul(fine, 32'd5) + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    d = sra(a, 2);
    sq = wmul(d, d);
    b = wmul(sra(sq, 11), p6);
    b = b + (wmul(a, p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(wmul(p3, sra(sq, 13)), 3) + sra(wmul(p2, a), 1), 18);
    a = sra(wmul(32'd32768 + a, p1), 15);
    if (a == 32'd0) begin
      pr = 32'd0;
    end else begin
      pr = wmul((32'd1048576 - ap) - sra(b, 12), 32'd3125);
      // large dividend: divide first, double afterwards
      if (pr < 32'h8000_0000) pr = (pr << 1) / a;
      else pr = (pr / a) << 1;
      y1 = sra(wmul(p9, wmul(pr >> 3, pr >> 3) >> 13), 12);
      y2 = sra(wmul(pr >> 2, p8), 13);
      pr = pr + sra(y1 + y2 + p7, 4);
    end
    a = fine - 32'd76800;
    d = sra(((ah << 14) - (h4 << 20)) - wmul(h5, a) + 32'd16384, 15);
    b = sra(wmul(a, h6), 10);
    b = sra(wmul(b, sra(wmul(a, h3), 11) + 32'd32768), 10) + 32'd2097152;
    b = sra(wmul(b, h2) + 32'd8192, 14);
    a = wmul(d, b);
    d = sra(a, 15);
    a = a - sra(wmul(sra(wmul(d, d), 7), h1), 4);
    if (a[31]) a = 32'd0;
    if (a > 32'd419430400) a = 32'd419430400;
    r.temperature_centideg = tmp[23:0];
    r.pressure_pascal = pr;
    r.humidity_q22_10 = 17'(a >> 12);
    return r;
  endfunction

  assign pending = readings_due.size();

  always @(posedge clk) begin
    out_item_t want;
    int        bad;
    bad = 0;
    if (rst) begin
      k_temp <= '0; k_plow <= '0; k_phigh <= '0; k_p9 <= '0; k_hum <= '0;
      errors <= 0;
      seen <= 0;
      readings_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen <= seen + 1;
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          bad++;
        end else begin
          want = readings_due.pop_front();
          if (want.temperature_centideg !== out_data.temperature_centideg) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     want.temperature_centideg, out_data.temperature_centideg);
            bad++;
          end
          if (want.pressure_pascal !== out_data.pressure_pascal) begin
            $display("%0t: pressure expected %0d actual %0d", $time,
                     want.pressure_pascal, out_data.pressure_pascal);
            bad++;
          end
          if (want.humidity_q22_10 !== out_data.humidity_q22_10) begin
            $display("%0t: humidity expected %0d actual %0d", $time,
                     want.humidity_q22_10, out_data.humidity_q22_10);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
      if (in_valid && !in_stall) readings_due.push_back(compensate(in_data));
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_TEMP:  k_temp  <= cfg_data[47:0];
          REG_PLOW:  k_plow  <= cfg_data;
          REG_PHIGH: k_phigh <= cfg_data;
          REG_P9:    k_p9    <= cfg_data[15:0];
          REG_HUM:   k_hum   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: tb/env_sensor_int32_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor compensation testbench
// Loads several calibration sets, from all-zero and all-ones to typical and
// random ones, and streams raw readings through the block in random bursts
// while the result side stalls; the checker scores every result.
// ----------------------------------------------------------------------------
module env_sensor_int32_compensation_tb;
  import envc_pkg::*;

  localparam int RunLimit = 400000;
  localparam int Drain    = 200;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  int                  errors, pending, seen;
  int                  cycles = 0;
  int                  sent = 0;
  int                  stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  env_sensor_int32_compensation uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .in_data, .out_valid, .out_stall, .out_data
  );

  env_sensor_int32_compensation_chk chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .in_data, .out_valid, .out_stall, .out_data, .errors, .pending, .seen
  );

  // Hard stop: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("env_sensor_int32_compensation_tb: errors");
      $finish;
    end
  end

  // Receiver back-pressure: its own pattern, changing mode now and then,
  // including long stretches with no stall at all.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (cycles % 7) < 3;
    endcase
  end

  // Drive one transaction and hold it until accepted.
  task automatic send_reading(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid for a random gap, often none.
  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every outstanding result has come back, then let the
  // pipeline settle before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic load_set(input int kind);
    logic [63:0] r0, r1, r2, r3, r4;
    case (kind)
      0: begin r0 = '0; r1 = '0; r2 = '0; r3 = '0; r4 = '0; end
      1: begin r0 = '1; r1 = '1; r2 = '1; r3 = '1; r4 = '1; end
      2: begin
        // typical calibration: T1..T3, P1..P9, H1..H6
        r0 = {16'd0, 16'd50, 16'd26435, 16'd27504};
        r1 = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
        r2 = {-16'sd7, 16'd15500, -16'sd7, 16'd140};
        r3 = 64'd6000;
        r4 = {8'd30, 12'd0, 12'd324, 8'd0, 16'd360, 8'd75};
      end
      3: begin
        r0 = {16'd0, 16'h8000, 16'h8000, 16'h0000};
        r1 = {16'h7fff, 16'h8000, 16'h7fff, 16'hffff};
        r2 = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        r3 = 64'h8000;
        r4 = {8'h80, 12'h800, 12'h7ff, 8'hff, 16'h8000, 8'hff};
      end
      default: begin
        r0 = {$urandom, $urandom}; r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom}; r3 = {$urandom, $urandom};
        r4 = {$urandom, $urandom};
        // keep some random sets near typical so the divisor is non-zero
        if ($urandom_range(0, 1) == 0) begin
          r1[15:0] = 16'd30000 + 16'($urandom_range(0, 20000));
          r1[63:16] = {16'd2855, 16'd3024, -16'sd10685} ^ 48'($urandom_range(0, 255));
        end
      end
    endcase
    write_reg(REG_TEMP, r0);
    write_reg(REG_PLOW, r1);
    write_reg(REG_PHIGH, r2);
    write_reg(REG_P9, r3);
    write_reg(REG_HUM, r4);
    // index beyond the register list: must be ignored
    write_reg(cfg_reg_t'(3'd7), '1);
  endtask

  function automatic in_item_t rand_reading();
    in_item_t it;
    it.raw_temperature = 20'($urandom);
    it.raw_pressure    = 20'($urandom);
    it.raw_humidity    = 16'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      // plausible conversions around room conditions
      it.raw_temperature = 20'd519888 + 20'($urandom_range(0, 65535)) - 20'd32768;
      it.raw_pressure    = 20'd415148 + 20'($urandom_range(0, 65535)) - 20'd32768;
      it.raw_humidity    = 16'd30000 + 16'($urandom_range(0, 16383));
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    int left;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of every raw field under several calibration sets.
    for (int k = 0; k < 4; k++) begin
      load_set(k);
      send_reading('{20'd0, 20'd0, 16'd0});
      send_reading('{20'hfffff, 20'hfffff, 16'hffff});
      send_reading('{20'd519888, 20'd415148, 16'd30000});
      send_reading('{20'd0, 20'hfffff, 16'd0});
      send_reading('{20'hfffff, 20'd0, 16'hffff});
      settle();
    end

    // Random: calibration changes between bursts of readings.
    for (int ph = 0; ph < 10; ph++) begin
      load_set(ph < 2 ? 2 + ph : 4);
      left = 200;
      while (left > 0) begin
        it = rand_reading();
        send_reading(it);
        left--;
        if ($urandom_range(0, 7) == 0) pause_sender();
      end
      settle();
    end

    $display("Covered %0d readings over 14 calibration sets, %0d results scored.",
             sent, seen);
    if (errors == 0) begin
      $display("env_sensor_int32_compensation_tb: clean");
    end else begin
      $display("env_sensor_int32_compensation_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/envc_pkg.sv
hw/rtl/envc_front.sv
hw/rtl/envc_queue.sv
hw/rtl/envc_div.sv
hw/rtl/envc_back.sv
hw/rtl/env_sensor_int32_compensation.sv
tb/env_sensor_int32_compensation_chk.sv
tb/env_sensor_int32_compensation_tb.sv
